// File: rtl/csvfp_pkg.sv
package csvfp_pkg;

  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  localparam logic [7:0] DELIMITER_RESET = 8'd44;

  // line stop codes
  localparam logic [1:0] STOP_NONE = 2'd0;
  localparam logic [1:0] STOP_NUL  = 2'd1;
  localparam logic [1:0] STOP_DONE = 2'd2;

  localparam logic KIND_CHAR      = 1'b0;
  localparam logic KIND_FIELD_END = 1'b1;

  // result queue: room for two items' worth of results
  localparam int RESULT_DEPTH = 4;
  localparam int PTR_W        = $clog2(RESULT_DEPTH);
  localparam int COUNT_W      = $clog2(RESULT_DEPTH + 1);

  typedef struct packed {
    logic [7:0] char_out;
    logic       kind;
    logic       end_of_record;
    logic       last_of_item;
  } result_t;

endpackage

// File: rtl/csvfp_byte_if.sv
interface csvfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;

  modport source (output valid, output char_in, output end_of_line, input ready);
  modport sink (input valid, input char_in, input end_of_line, output ready);
endinterface

// File: rtl/csvfp_result_if.sv
interface csvfp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       kind;
  logic       end_of_record;
  logic       last_of_item;

  modport source (output valid, output char_out, output kind, output end_of_record,
                  output last_of_item, input ready);
  modport sink (input valid, input char_out, input kind, input end_of_record,
                input last_of_item, output ready);
endinterface

// File: rtl/csv_field_parser_unit.sv
// Streaming CSV field splitter. One byte of a line is transferred in per clock on
// chars while chars.ready is high, with end_of_line on the last byte; each byte
// gives zero, one or two results on fields (field characters and field-end marks,
// end_of_record on the mark that closes the record, last_of_item on the final
// result of a byte). A byte is taken into an input register, parsed there by one
// pass of logic against the quote/stop state, and its results are written into a
// four-entry result queue; the byte waits while the queue lacks room. The queue
// keeps input at one byte per clock while the sink drains one result per clock
// and no byte gives two; a last byte of a line with a result of its own gives
// two and can fill the queue and stall input. A result reaches fields through the
// input register and the queue. The delimiter register (reset ',') is written
// through delimiter_we/delimiter_data; the user must write it only while the
// block is idle, which the block itself does not enforce.
module csv_field_parser_unit
  import csvfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         delimiter_we,
  input  logic [7:0]   delimiter_data,
  csvfp_byte_if.sink   chars,
  csvfp_result_if.source fields
);

  logic [7:0] delimiter;

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eol;

  // line state
  logic       in_quotes;
  logic       quote_pending;
  logic       field_started;
  logic [1:0] stop_mode;

  logic       in_quotes_next;
  logic       quote_pending_next;
  logic       field_started_next;
  logic [1:0] stop_mode_next;

  // result queue
  result_t             queue [RESULT_DEPTH];
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W-1:0]    wr_ptr;
  logic [COUNT_W-1:0]  count;

  result_t    res0;
  result_t    res1;
  logic [1:0] res_n;

  logic pop;
  logic fire;
  logic room;

  assign pop  = fields.valid && fields.ready;
  assign room = (count <= COUNT_W'(RESULT_DEPTH - 2)) ||
                ((count == COUNT_W'(RESULT_DEPTH - 1)) && pop);
  assign fire = in_valid && room;
  assign chars.ready = !in_valid || fire;

  // delimiter register
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIMITER_RESET;
    end else if (delimiter_we) begin
      delimiter <= delimiter_data;
    end
  end

  // hold the byte until the queue has room for its results
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
    if (chars.valid && chars.ready) begin
      in_char <= chars.char_in;
      in_eol  <= chars.end_of_line;
    end
  end

  // parse one byte
  always_comb begin
    logic handled;
    logic record_done;
    result_t r;

    handled            = 1'b0;
    record_done        = (stop_mode >= STOP_DONE);
    in_quotes_next     = in_quotes;
    quote_pending_next = quote_pending;
    field_started_next = field_started;
    stop_mode_next     = stop_mode;
    res0  = '0;
    res1  = '0;
    res_n = 2'd0;
    r     = '0;

    if (stop_mode == STOP_NONE) begin
      // resolve a quote seen on the previous byte
      if (quote_pending) begin
        quote_pending_next = 1'b0;
        if (in_char == QUOTE_BYTE) begin
          res0 = '{char_out: QUOTE_BYTE, kind: KIND_CHAR, end_of_record: 1'b0,
                   last_of_item: 1'b0};
          res_n = 2'd1;
          field_started_next = 1'b1;
          handled = 1'b1;
        end else begin
          in_quotes_next = 1'b0;
        end
      end
      if (!handled) begin
        if (in_char == NUL_BYTE) begin
          stop_mode_next = STOP_NUL;
        end else if (!in_quotes_next && !field_started_next && in_char == QUOTE_BYTE) begin
          in_quotes_next = 1'b1;
        end else if (in_quotes_next && in_char == QUOTE_BYTE) begin
          if (in_eol) begin
            in_quotes_next = 1'b0;
          end else begin
            quote_pending_next = 1'b1;
          end
        end else if (!in_quotes_next && in_char == delimiter) begin
          res0 = '{char_out: 8'd0, kind: KIND_FIELD_END, end_of_record: 1'b0,
                   last_of_item: 1'b0};
          res_n = 2'd1;
          field_started_next = 1'b0;
        end else if (!in_quotes_next && (in_char == CR_BYTE || in_char == LF_BYTE)) begin
          res0 = '{char_out: 8'd0, kind: KIND_FIELD_END, end_of_record: 1'b1,
                   last_of_item: 1'b0};
          res_n = 2'd1;
          stop_mode_next = STOP_DONE;
          record_done = 1'b1;
        end else begin
          res0 = '{char_out: in_char, kind: KIND_CHAR, end_of_record: 1'b0,
                   last_of_item: 1'b0};
          res_n = 2'd1;
          field_started_next = 1'b1;
        end
      end
    end

    // close the record at end of line and clear the line state
    if (in_eol) begin
      if (!record_done) begin
        r = '{char_out: 8'd0, kind: KIND_FIELD_END, end_of_record: 1'b1,
              last_of_item: 1'b0};
        if (res_n == 2'd0) begin
          res0 = r;
        end else begin
          res1 = r;
        end
        res_n = res_n + 2'd1;
      end
      in_quotes_next     = 1'b0;
      quote_pending_next = 1'b0;
      field_started_next = 1'b0;
      stop_mode_next     = STOP_NONE;
    end

    // mark the final result of this byte
    if (res_n == 2'd2) begin
      res1.last_of_item = 1'b1;
    end else if (res_n == 2'd1) begin
      res0.last_of_item = 1'b1;
    end
  end

  // advance line state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes     <= 1'b0;
      quote_pending <= 1'b0;
      field_started <= 1'b0;
      stop_mode     <= STOP_NONE;
    end else if (fire) begin
      in_quotes     <= in_quotes_next;
      quote_pending <= quote_pending_next;
      field_started <= field_started_next;
      stop_mode     <= stop_mode_next;
    end
  end

  // write results into the queue
  always_ff @(posedge clk) begin
    if (fire && res_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (fire && res_n == 2'd2) begin
      queue[wr_ptr + PTR_W'(1)] <= res1;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (fire) begin
        wr_ptr <= wr_ptr + PTR_W'(res_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (fire ? COUNT_W'(res_n) : COUNT_W'(0)) - (pop ? COUNT_W'(1) : COUNT_W'(0));
    end
  end

  assign fields.valid         = (count != '0);
  assign fields.char_out      = queue[rd_ptr].char_out;
  assign fields.kind          = queue[rd_ptr].kind;
  assign fields.end_of_record = queue[rd_ptr].end_of_record;
  assign fields.last_of_item  = queue[rd_ptr].last_of_item;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(RESULT_DEPTH))
    else $error("result queue overfilled");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    fire && in_eol |=> !in_quotes && !quote_pending && !field_started &&
                       stop_mode == STOP_NONE)
    else $error("line state not cleared at end of line");

  a_pending_in_quotes: assert property (@(posedge clk) disable iff (rst)
    quote_pending |-> in_quotes && stop_mode == STOP_NONE)
    else $error("pending quote outside a quoted section");

  a_stop_code: assert property (@(posedge clk) disable iff (rst)
    stop_mode <= STOP_DONE)
    else $error("unused stop code reached");
`endif

endmodule
